// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define RSSM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rssm check failed");

// Next-cycle implication, disabled while reset is active.
`define RSSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rssm check failed");

`endif

// File: src/rssm_pkg.sv
package rssm_pkg;

  localparam int DATA_BITS    = 32;
  localparam int HIST_ENTRIES = 1024;
  localparam int KEY_BITS     = $clog2(HIST_ENTRIES);
  localparam int DIGIT_BITS   = KEY_BITS - 1;
  localparam int SUM_W        = DATA_BITS + KEY_BITS + 1;
  localparam int BITS_W       = 6;
  localparam int GAP_W        = DATA_BITS + 1;

  typedef enum logic [1:0] {
    ST_RADIX = 2'd0,
    ST_NEAR  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ERROR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_STREAM,
    S_DRAIN,
    S_SCAN,
    S_TAIL,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] sample;
    logic                        pass_end;
  } in_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [DATA_BITS-1:0] median_value;
  } out_t;

  typedef struct packed {
    logic                clear_wr;
    logic                scan_rd;
    logic                scan_init;
    logic                finish;
    logic                accept;
    logic [KEY_BITS-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic near;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: src/rssm_hist_ram.sv
module rssm_hist_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [rssm_pkg::KEY_BITS-1:0] waddr_i,
  input  logic [rssm_pkg::DATA_BITS-1:0] wdata_i,
  input  logic [rssm_pkg::KEY_BITS-1:0] raddr_i,
  output logic [rssm_pkg::DATA_BITS-1:0] rdata_o
);
  import rssm_pkg::*;

  logic [DATA_BITS-1:0] mem [HIST_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/rssm_ctrl.sv
module rssm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_pass_end_i,
  input  rssm_pkg::dp_stat_t stat_i,
  output logic               in_ready_o,
  output rssm_pkg::dp_cmd_t  cmd_o
);
  import rssm_pkg::*;

  localparam logic [KEY_BITS-1:0] KeyLast = KEY_BITS'(HIST_ENTRIES - 1);

  ctrl_state_e         state_q, state_d;
  logic [KEY_BITS-1:0] cnt_q, cnt_d;
  logic                accept;

  assign accept = in_valid_i && (state_q == S_STREAM);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q == KeyLast) state_d = S_STREAM;
      end
      S_STREAM: begin
        if (accept && in_pass_end_i) state_d = stat_i.near ? S_FINISH : S_DRAIN;
      end
      S_DRAIN: state_d = S_SCAN;
      S_SCAN: begin
        if (cnt_q == KeyLast) state_d = S_TAIL;
      end
      S_TAIL: state_d = S_FINISH;
      S_FINISH: begin
        if (!stat_i.out_busy) state_d = S_STREAM;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cnt_d          = '0;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.addr     = cnt_q;
    case (state_q)
      S_CLEAR: begin
        cnt_d          = cnt_q + 1'b1;
        cmd_o.clear_wr = 1'b1;
      end
      S_STREAM: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = accept;
      end
      S_DRAIN: cmd_o.scan_init = 1'b1;
      S_SCAN: begin
        cnt_d         = cnt_q + 1'b1;
        cmd_o.scan_rd = 1'b1;
      end
      S_TAIL: cmd_o.scan_rd = 1'b0;
      S_FINISH: cmd_o.finish = !stat_i.out_busy;
      default: cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: src/rssm_datapath.sv
module rssm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rssm_pkg::dp_cmd_t  cmd_i,
  input  rssm_pkg::in_t      in_data_i,
  input  logic               out_ready_i,
  output rssm_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  output rssm_pkg::out_t     out_data_o
);
  import rssm_pkg::*;

  localparam logic [BITS_W-1:0] BitsTotal = BITS_W'(DATA_BITS);
  localparam logic [BITS_W-1:0] BitsDigit = BITS_W'(DIGIT_BITS);

  logic [DATA_BITS-1:0]        prefix_q, prefix_d;
  logic [BITS_W-1:0]           bits_q, bits_d;
  logic [DATA_BITS-1:0]        rank_q, rank_d;
  logic [DATA_BITS-1:0]        count_q, count_d;
  logic                        even_q, even_d;
  logic signed [DATA_BITS-1:0] nb_q, nb_d;
  logic [GAP_W-1:0]            gap_q, gap_d;
  logic                        near_q, near_d;
  logic                        s1_valid_q;
  logic [KEY_BITS-1:0]         s1_key_q;
  logic                        wr_valid_q;
  logic [KEY_BITS-1:0]         wr_key_q;
  logic [DATA_BITS-1:0]        wr_val_q;
  logic                        scan_dv_q;
  logic [KEY_BITS-1:0]         scan_key_q;
  logic [SUM_W-1:0]            sum_q, sum_d;
  logic                        found_q, found_d;
  logic [KEY_BITS-1:0]         fkey_q, fkey_d;
  logic [SUM_W-1:0]            below_q, below_d;
  logic                        out_valid_q, out_valid_d;
  out_t                        out_q, out_d;

  logic [DATA_BITS-1:0]        v;
  logic [BITS_W-1:0]           left, cl, shift;
  logic [DATA_BITS-1:0]        dmask, digit;
  logic                        match;
  logic [KEY_BITS-1:0]         key;
  logic signed [DATA_BITS-1:0] med;
  logic [GAP_W-1:0]            gap;
  logic                        hit;
  logic [DATA_BITS-1:0]        rdata, inc;
  logic                        we;
  logic [KEY_BITS-1:0]         waddr, raddr;
  logic [DATA_BITS-1:0]        wdata;
  logic [SUM_W-1:0]            sum_new;
  logic [GAP_W-1:0]            avg_sum, avg_half;
  logic [DATA_BITS-1:0]        rank_new, prefix_new;
  logic [BITS_W-1:0]           bits_new;

  assign v     = in_data_i.sample;
  assign left  = BitsTotal - bits_q;
  assign cl    = (left < BitsDigit) ? left : BitsDigit;
  assign shift = left - cl;
  assign dmask = ~({DATA_BITS{1'b1}} << cl);
  assign digit = (v >> shift) & dmask;
  assign match = (bits_q == '0) || ((v >> left) == prefix_q);
  assign key   = KEY_BITS'(({{(DATA_BITS-1){1'b0}}, ~v[DATA_BITS-1]} << cl) | digit);

  assign med = prefix_q;
  assign gap = {med[DATA_BITS-1], med} - {v[DATA_BITS-1], v};
  assign hit = $signed(v) < med;

  assign inc   = ((wr_valid_q && (wr_key_q == s1_key_q)) ? wr_val_q : rdata) + 1'b1;
  assign we    = s1_valid_q || cmd_i.clear_wr || cmd_i.scan_rd;
  assign waddr = s1_valid_q ? s1_key_q : cmd_i.addr;
  assign wdata = s1_valid_q ? inc : '0;
  assign raddr = cmd_i.scan_rd ? cmd_i.addr : key;

  rssm_hist_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sum_new    = sum_q + SUM_W'(rdata);
  assign avg_sum    = {nb_q[DATA_BITS-1], nb_q} + {med[DATA_BITS-1], med};
  assign avg_half   = $unsigned($signed(avg_sum + GAP_W'(avg_sum[GAP_W-1])) >>> 1);
  assign rank_new   = rank_q - below_q[DATA_BITS-1:0];
  assign prefix_new = (prefix_q << cl) | (DATA_BITS'(fkey_q) & dmask);
  assign bits_new   = bits_q + cl;

  always_comb begin
    prefix_d    = prefix_q;
    bits_d      = bits_q;
    rank_d      = rank_q;
    count_d     = count_q;
    even_d      = even_q;
    nb_d        = nb_q;
    gap_d       = gap_q;
    near_d      = near_q;
    sum_d       = sum_q;
    found_d     = found_q;
    fkey_d      = fkey_q;
    below_d     = below_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.accept) begin
      if (near_q) begin
        if (hit && (gap < gap_q)) begin
          gap_d = gap;
          nb_d  = in_data_i.sample;
        end
      end else if (bits_q == '0) begin
        count_d = count_q + 1'b1;
      end
    end

    if (cmd_i.scan_init) begin
      sum_d   = '0;
      found_d = 1'b0;
      if (bits_q == '0) begin
        rank_d = count_q >> 1;
        even_d = !count_q[0];
      end
    end

    if (scan_dv_q) begin
      sum_d = sum_new;
      if (!found_q && (sum_new > SUM_W'(rank_q))) begin
        found_d = 1'b1;
        fkey_d  = scan_key_q;
        below_d = sum_q;
      end
    end

    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (near_q || !found_q || (count_q == '0) ||
          ((bits_new >= BitsTotal) && (!even_q || (rank_new != '0)))) begin
        if (near_q) begin
          out_d.status       = ST_DONE;
          out_d.median_value = avg_half[DATA_BITS-1:0];
        end else if (!found_q || (count_q == '0)) begin
          out_d.status = ST_ERROR;
        end else begin
          out_d.status       = ST_DONE;
          out_d.median_value = prefix_new;
        end
        prefix_d = '0;
        bits_d   = '0;
        rank_d   = '0;
        count_d  = '0;
        even_d   = 1'b0;
        nb_d     = '0;
        gap_d    = '1;
        near_d   = 1'b0;
      end else begin
        prefix_d = prefix_new;
        bits_d   = bits_new;
        rank_d   = rank_new;
        if (bits_new < BitsTotal) begin
          out_d.status = ST_RADIX;
        end else begin
          out_d.status = ST_NEAR;
          near_d       = 1'b1;
          nb_d         = '0;
          gap_d        = '1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= '0;
      bits_q      <= '0;
      rank_q      <= '0;
      count_q     <= '0;
      even_q      <= 1'b0;
      nb_q        <= '0;
      gap_q       <= '1;
      near_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      wr_valid_q  <= 1'b0;
      scan_dv_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prefix_q    <= prefix_d;
      bits_q      <= bits_d;
      rank_q      <= rank_d;
      count_q     <= count_d;
      even_q      <= even_d;
      nb_q        <= nb_d;
      gap_q       <= gap_d;
      near_q      <= near_d;
      s1_valid_q  <= cmd_i.accept && !near_q && match;
      wr_valid_q  <= s1_valid_q;
      scan_dv_q   <= cmd_i.scan_rd;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_key_q   <= key;
    wr_key_q   <= s1_key_q;
    wr_val_q   <= inc;
    scan_key_q <= cmd_i.addr;
    sum_q      <= sum_d;
    fkey_q     <= fkey_d;
    below_q    <= below_d;
    out_q      <= out_d;
  end

  assign stat_o.near     = near_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// File: src/radix_select_stream_median.sv
// Streaming transactions are taken one per cycle while in_ready_o is high; a result follows the last one of each pass.
// After a radix pass ends, the block runs a drain step, a scan of all 1024 histogram entries, a tail and a finish step.
// After the nearest-below pass ends, only the finish step runs. A full median takes 4 or 5 passes.
// The histogram scan, one entry per cycle on the memory port, sets the gap between passes.
// After reset, a clearing pass through all 1024 histogram entries runs before any transaction.
module radix_select_stream_median (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rssm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rssm_pkg::out_t out_data_o
);
  import rssm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rssm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_pass_end_i(in_data_i.pass_end),
    .stat_i       (stat),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd)
  );

  rssm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_ready_i(out_ready_i),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

// File: src/rssm_checker.sv
`include "assert_macros.svh"

module rssm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input rssm_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rssm_pkg::out_t out_data_o
);
  import rssm_pkg::*;

  `RSSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `RSSM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  `RSSM_ASSERT_IMPL(a_value_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status != ST_DONE), out_data_o.median_value == '0)
  `RSSM_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_valid_i && in_ready_o, !$rose(out_valid_o))

endmodule

bind radix_select_stream_median rssm_checker u_rssm_checker (.*);

// File: verif/tb_radix_select_stream_median.sv
module tb_radix_select_stream_median;
  import rssm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int          ITEM_GOAL   = 1100;
  localparam int          MAX_REPORTS = 10;

  class median_scoreboard;
    bit [31:0]         hist [HIST_ENTRIES];
    longint unsigned   prefix;
    int unsigned       bits_done;
    bit [31:0]         rank;
    bit [31:0]         count;
    bit                even;
    longint            lower;
    longint unsigned   gap;
    bit                near_pass;
    out_t              expected_q [$];
    status_e           last_status;
    int                mismatches;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      foreach (hist[i]) hist[i] = '0;
      prefix    = 0;
      bits_done = 0;
      rank      = '0;
      count     = '0;
      even      = 1'b0;
      lower     = 0;
      gap       = 64'h1_FFFF_FFFF;
      near_pass = 1'b0;
    endfunction

    function longint as_signed(longint unsigned x);
      logic signed [31:0] t;
      t = x[31:0];
      return longint'(t);
    endfunction

    function void push_result(status_e st, longint val);
      out_t e;
      e.status       = st;
      e.median_value = val[31:0];
      expected_q.push_back(e);
      last_status = st;
    endfunction

    function void note_input(in_t d);
      longint unsigned v, key, sum, below;
      longint          med, s;
      int unsigned     cl, sh;
      int              k;
      bit              found;
      v = {32'b0, d.sample};
      if (near_pass) begin
        med = as_signed(prefix);
        s   = as_signed(v);
        if (s < med && longint'(med - s) < gap) begin
          gap   = med - s;
          lower = s;
        end
        if (d.pass_end) begin
          med = (lower + med) / 2;
          clear_state();
          push_result(ST_DONE, med);
        end
        return;
      end
      cl = (DATA_BITS - bits_done < DIGIT_BITS) ? DATA_BITS - bits_done : DIGIT_BITS;
      if (bits_done == 0 || (v >> (DATA_BITS - bits_done)) == prefix) begin
        sh  = DATA_BITS - bits_done - cl;
        key = ((v[31] ? 64'd0 : 64'd1) << cl) | ((v >> sh) & ((64'd1 << cl) - 1));
        hist[key] = hist[key] + 1;
        if (bits_done == 0) count = count + 1;
      end
      if (!d.pass_end) return;
      if (bits_done == 0) begin
        rank = count >> 1;
        even = ~count[0];
      end
      sum   = 0;
      below = 0;
      found = 1'b0;
      for (k = 0; k < HIST_ENTRIES; k++) begin
        sum += hist[k];
        if (sum > rank) begin
          below = sum - hist[k];
          found = 1'b1;
          break;
        end
      end
      foreach (hist[i]) hist[i] = '0;
      if (!found || count == 0) begin
        clear_state();
        push_result(ST_ERROR, 0);
        return;
      end
      rank      = rank - below[31:0];
      prefix    = ((prefix << cl) | (longint'(k) & ((64'd1 << cl) - 1))) & 64'hFFFF_FFFF;
      bits_done = bits_done + cl;
      if (bits_done < DATA_BITS) begin
        push_result(ST_RADIX, 0);
      end else if (!even || rank > 0) begin
        med = as_signed(prefix);
        clear_state();
        push_result(ST_DONE, med);
      end else begin
        near_pass = 1'b1;
        lower     = 0;
        gap       = 64'h1_FFFF_FFFF;
        push_result(ST_NEAR, 0);
      end
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: status %0d value %0d", got.status, got.median_value);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.median_value !== e.median_value) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Mismatch: expected status %0d value %0d, got status %0d value %0d",
                   e.status, e.median_value, got.status, got.median_value);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  median_scoreboard sb = new();
  int               items_sent = 0;
  int               stream_idx = 0;
  bit               sender_quiet = 1'b0;
  bit               random_part = 1'b0;

  radix_select_stream_median dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned cycles;
    int          hold;
    cycles = 0;
    hold   = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles == 20000) hold = 6000;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (cycles > 100000 && cycles < 160000) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 36);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic send_item(logic [31:0] value, logic last);
    in_t d;
    bit  rdy;
    if (!sender_quiet && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    d.sample   = value;
    d.pass_end = last;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_input(d);
    items_sent++;
  endtask

  task automatic run_stream(logic [31:0] values [$]);
    logic [31:0] pass_vals [$];
    int          n;
    do begin
      pass_vals = values;
      if (random_part && $urandom_range(99) < 6) begin
        pass_vals.delete();
        n = $urandom_range(1, 6);
        repeat (n) pass_vals.push_back($urandom());
      end
      foreach (pass_vals[i]) send_item(pass_vals[i], i == pass_vals.size() - 1);
    end while (sb.last_status == ST_RADIX || sb.last_status == ST_NEAR);
    stream_idx++;
  endtask

  function automatic logic [31:0] pick_value(int mode, logic [31:0] a, logic [31:0] b);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(8) - 4;
      2: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF) + $urandom_range(3) - 1;
      3: return $urandom_range(1) ? a : b;
      default: return a;
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] vals [$];
    logic [31:0] a, b;
    int          n, mode;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    vals = '{32'h8000_0000};                 run_stream(vals);
    vals = '{32'h7FFF_FFFF};                 run_stream(vals);
    vals = '{32'h8000_0000, 32'h7FFF_FFFF};  run_stream(vals);
    vals = '{32'd5, 32'd5};                  run_stream(vals);
    vals = '{32'hFFFF_FFFF, 32'd0};          run_stream(vals);
    vals = '{32'd3, 32'hFFFF_FFFD, 32'd3};   run_stream(vals);
    vals = '{32'd4, 32'd1, 32'd2, 32'd1};    run_stream(vals);

    random_part = 1'b1;
    while (items_sent < ITEM_GOAL) begin
      sender_quiet = (stream_idx >= 25 && stream_idx < 40);
      if (stream_idx == 12) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
        repeat (10) @(posedge clk_i);
      end
      mode = $urandom_range(4);
      a    = $urandom();
      b    = $urandom_range(1) ? a + 1 : $urandom();
      n    = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
      vals.delete();
      repeat (n) vals.push_back(pick_value(mode, a, b));
      run_stream(vals);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: radix_select_stream_median.f
+incdir+src
src/rssm_pkg.sv
src/rssm_hist_ram.sv
src/rssm_ctrl.sv
src/rssm_datapath.sv
src/radix_select_stream_median.sv
src/rssm_checker.sv
verif/tb_radix_select_stream_median.sv
